[rtl/core/fdes_pkg.sv]
// Package for the FAT directory entry scanner.
// Holds entry layout constants, controller states, and the command and status structs.
// No dependencies.
package fdes_pkg;

	// Entry layout at the standard short-entry offsets.
	localparam logic [4:0] ENTRY_LAST_POS = 5'd31;
	localparam int NAME_LEN = 11;
	localparam int BASE_LEN = 8;
	localparam logic [4:0] ATTR_POS = 5'd11;
	localparam logic [4:0] TENTHS_POS = 5'd13;
	localparam int WORD_BASE_POS = 14;
	localparam int NUM_WORDS = 7;
	localparam logic [2:0] SIZE_POS_TAG = 3'b111;

	// Indexes of the gathered 16-bit words.
	localparam int WORD_CTIME = 0;
	localparam int WORD_CDATE = 1;
	localparam int WORD_ADATE = 2;
	localparam int WORD_CLUS_HI = 3;
	localparam int WORD_WTIME = 4;
	localparam int WORD_WDATE = 5;
	localparam int WORD_CLUS_LO = 6;

	// Character codes.
	localparam logic [7:0] DELETED_MARK = 8'hE5;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] UPPER_Z = 8'h5A;

	// Name walk slots: eight base characters, the dot, three extension characters.
	localparam logic [3:0] DOT_SLOT = 4'(BASE_LEN);
	localparam logic [3:0] LAST_SLOT = 4'(NAME_LEN);

	// Result kinds.
	localparam logic KIND_NAME = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef enum logic [2:0] {
		S_SCAN = 3'b001,
		S_NAME = 3'b010,
		S_END  = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic mark_end;
		logic slot_clr;
		logic slot_adv;
		logic load_char;
		logic load_end;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic entry_done;
		logic skip_now;
		logic name0_zero;
		logic drop_entry;
		logic slot_emits;
		logic slot_final;
		logic out_free;
	} status_t;

	// Lower-case an upper-case letter; everything else passes through.
	function automatic logic [7:0] lower_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + SPACE_CHAR;
		end
		return r;
	endfunction

endpackage

[rtl/core/fdes_ctrl.sv]
// Controller state machine for the FAT directory entry scanner.
// Depends on fdes_pkg for the state type and the command and status structs.
module fdes_ctrl import fdes_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// Next state and commands.
	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = (state_q == S_SCAN);
		unique case (state_q)
			S_SCAN: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.entry_done && !status.skip_now) begin
						if (status.name0_zero) begin
							cmd.mark_end = 1'b1;
							state_d = S_END;
						end else if (!status.drop_entry) begin
							cmd.slot_clr = 1'b1;
							state_d = S_NAME;
						end
					end
				end
			end
			S_NAME: begin
				if (status.out_free) begin
					cmd.slot_adv = 1'b1;
					cmd.load_char = status.slot_emits;
					if (status.slot_final) begin
						state_d = S_SCAN;
					end
				end
			end
			S_END: begin
				if (status.out_free) begin
					cmd.load_end = 1'b1;
					state_d = S_SCAN;
				end
			end
			default: begin
				state_d = S_SCAN;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SCAN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/fdes_datapath.sv]
// Datapath for the FAT directory entry scanner: entry position, field stores,
// name walk counter and the result register. Depends on fdes_pkg.
module fdes_datapath import fdes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic [7:0]  dir_byte,
	input  logic        start_of_scan,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        result_kind,
	output logic [7:0]  name_char,
	output logic [7:0]  attributes,
	output logic [31:0] first_cluster,
	output logic [31:0] file_length,
	output logic [15:0] write_time,
	output logic [15:0] write_date,
	output logic [15:0] create_time,
	output logic [15:0] create_date,
	output logic [15:0] access_date,
	output logic [7:0]  create_tenths,
	output logic        last
);

	logic        skip_cfg_q;
	logic [4:0]  pos_q;
	logic        skipping_q;
	logic        ended_q;
	logic [3:0]  slot_q;
	logic        out_valid_q;

	logic [7:0]  name_q [NAME_LEN];
	logic [7:0]  attr_q;
	logic [7:0]  tenths_q;
	logic [15:0] word_q [NUM_WORDS];
	logic [31:0] size_q;

	logic [4:0]  eff_pos;
	logic        eff_ended;
	logic        eff_skip;
	logic [3:0]  name_idx;
	logic [7:0]  raw_char;
	logic [7:0]  slot_char;
	logic [2:0]  ext_space;
	logic        slot_last;
	logic        out_free;

	// A request with the scan flag restarts position, end flag and skip flag.
	assign eff_pos = start_of_scan ? '0 : pos_q;
	assign eff_ended = start_of_scan ? 1'b0 : ended_q;
	assign eff_skip = start_of_scan ? skip_cfg_q : skipping_q;

	// Character selection for the current name walk slot.
	assign name_idx = (slot_q < DOT_SLOT) ? slot_q : slot_q - 4'd1;
	assign raw_char = name_q[name_idx];
	assign slot_char = (slot_q == DOT_SLOT) ? DOT_CHAR : lower_char(raw_char);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ext_space[k] = (name_q[BASE_LEN + k] == SPACE_CHAR);
		end
	end

	// The last result is the final non-space character after the dot, or the dot itself.
	always_comb begin
		case (slot_q)
			DOT_SLOT:                slot_last = &ext_space;
			4'(DOT_SLOT + 4'd1):     slot_last = ext_space[1] & ext_space[2];
			4'(DOT_SLOT + 4'd2):     slot_last = ext_space[2];
			LAST_SLOT:               slot_last = 1'b1;
			default:                 slot_last = 1'b0;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	// Status toward the controller.
	always_comb begin
		status.entry_done = !eff_ended && (eff_pos == ENTRY_LAST_POS);
		status.skip_now = eff_skip;
		status.name0_zero = (name_q[0] == 8'd0);
		status.drop_entry = (name_q[0] == DELETED_MARK) || (name_q[2] == 8'd0);
		status.slot_emits = (slot_q == DOT_SLOT) || (raw_char != SPACE_CHAR);
		status.slot_final = (slot_q == LAST_SLOT);
		status.out_free = out_free;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_cfg_q <= 1'b1;
			pos_q <= '0;
			skipping_q <= 1'b0;
			ended_q <= 1'b0;
			slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				skip_cfg_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				pos_q <= eff_ended ? eff_pos : eff_pos + 5'd1;
				ended_q <= eff_ended | cmd.mark_end;
				skipping_q <= (!eff_ended && eff_pos == ENTRY_LAST_POS) ? 1'b0 : eff_skip;
			end
			if (cmd.slot_clr) begin
				slot_q <= '0;
			end else if (cmd.slot_adv) begin
				slot_q <= slot_q + 4'd1;
			end
			if (cmd.load_char || cmd.load_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Field stores, written little-endian at the entry offsets.
	always_ff @(posedge clk) begin
		if (cmd.accept && !eff_ended) begin
			if (eff_pos < 5'(NAME_LEN)) begin
				name_q[eff_pos[3:0]] <= dir_byte;
			end
			if (eff_pos == ATTR_POS) begin
				attr_q <= dir_byte;
			end
			if (eff_pos == TENTHS_POS) begin
				tenths_q <= dir_byte;
			end
			for (int w = 0; w < NUM_WORDS; w++) begin
				if (eff_pos == 5'(WORD_BASE_POS + 2 * w)) begin
					word_q[w][7:0] <= dir_byte;
				end else if (eff_pos == 5'(WORD_BASE_POS + 2 * w + 1)) begin
					word_q[w][15:8] <= dir_byte;
				end
			end
			if (eff_pos[4:2] == SIZE_POS_TAG) begin
				case (eff_pos[1:0])
					2'd0:    size_q[7:0] <= dir_byte;
					2'd1:    size_q[15:8] <= dir_byte;
					2'd2:    size_q[23:16] <= dir_byte;
					default: size_q[31:24] <= dir_byte;
				endcase
			end
		end
	end

	// Result register; it holds its own copy of the metadata so scanning can go on.
	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			result_kind <= KIND_NAME;
			name_char <= slot_char;
			attributes <= attr_q;
			first_cluster <= {word_q[WORD_CLUS_HI], word_q[WORD_CLUS_LO]};
			file_length <= size_q;
			write_time <= word_q[WORD_WTIME];
			write_date <= word_q[WORD_WDATE];
			create_time <= word_q[WORD_CTIME];
			create_date <= word_q[WORD_CDATE];
			access_date <= word_q[WORD_ADATE];
			create_tenths <= tenths_q;
			last <= slot_last;
		end else if (cmd.load_end) begin
			result_kind <= KIND_END;
			name_char <= '0;
			attributes <= '0;
			first_cluster <= '0;
			file_length <= '0;
			write_time <= '0;
			write_date <= '0;
			create_time <= '0;
			create_date <= '0;
			access_date <= '0;
			create_tenths <= '0;
			last <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/fat_directory_entry_scanner.sv]
// Top level of the FAT directory entry scanner.
// Instantiates fdes_ctrl and fdes_datapath; depends on fdes_pkg.
//
// Usage:
// The input channel (in_valid/in_ready) carries one directory byte per request,
// with start_of_scan set on the first byte of a scan. Bytes are cut into 32-byte
// short entries. The output channel (out_valid/out_ready) carries one cleaned
// name character per request with the entry metadata, last set on the final one,
// or a single end-of-directory request when an entry's first name byte is zero.
// cfg_wr_en/cfg_wr_data write skip_first_entry, which takes effect at the next
// start_of_scan.
// Timing: bytes are taken one per cycle while the controller scans. After an entry's last
// byte the name walk steps the controller through twelve slots, one per cycle while the
// result register is free; a result is loaded only for the dot and each non-space
// character, so leading spaces hold back the first result.
// Bytes are not taken during the walk.
// A stalled receiver holds the result register; the walk waits for it to empty.
// Reset clears position, skip and end flags and sets skip_first_entry to 1.
module fat_directory_entry_scanner import fdes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  dir_byte,
	input  logic        start_of_scan,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  name_char,
	output logic [7:0]  attributes,
	output logic [31:0] first_cluster,
	output logic [31:0] file_length,
	output logic [15:0] write_time,
	output logic [15:0] write_date,
	output logic [15:0] create_time,
	output logic [15:0] create_date,
	output logic [15:0] access_date,
	output logic [7:0]  create_tenths,
	output logic        last
);

	cmd_t    cmd;
	status_t status;

	// Controller.
	fdes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	fdes_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.dir_byte      (dir_byte),
		.start_of_scan (start_of_scan),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.name_char     (name_char),
		.attributes    (attributes),
		.first_cluster (first_cluster),
		.file_length   (file_length),
		.write_time    (write_time),
		.write_date    (write_date),
		.create_time   (create_time),
		.create_date   (create_date),
		.access_date   (access_date),
		.create_tenths (create_tenths),
		.last          (last)
	);

	// The result register is never loaded while a result still waits.
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_char || cmd.load_end) |-> (!out_valid || out_ready))
		else $error("result register loaded while occupied");

	// An end-of-directory result is always a single final request with no name.
	a_end_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_END) |-> (last && name_char == 8'd0))
		else $error("malformed end-of-directory result");

	// A name walk starts only on an accepted byte.
	a_walk_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_clr |-> (in_valid && in_ready))
		else $error("name walk started without an accepted byte");

endmodule

[tb/sv/testbench.sv]
// Testbench for fat_directory_entry_scanner: streams 32-byte directory entries
// and checks every name character and end marker against a local prediction.
// Depends on fdes_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module testbench;
	import fdes_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int SETTLE_CYCLES = 48;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int REPORT_LINES = 30;
	localparam logic [7:0] NUL_CHAR = 8'h00;
	localparam logic [7:0] LFN_ATTR = 8'h0F;
	localparam logic [7:0] DIGIT_0 = 8'h30;

	typedef enum int {ENT_NAMED, ENT_DELETED, ENT_LONG_NAME, ENT_END} entry_kind_t;

	// One result as it leaves the scanner.
	typedef struct packed {
		logic        kind;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [31:0] cluster;
		logic [31:0] length;
		logic [15:0] wtime;
		logic [15:0] wdate;
		logic [15:0] ctime;
		logic [15:0] cdate;
		logic [15:0] adate;
		logic [7:0]  tenths;
		logic        last_flag;
	} dir_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  dir_byte;
	logic        start_of_scan;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [7:0]  name_char;
	logic [7:0]  attributes;
	logic [31:0] first_cluster;
	logic [31:0] file_length;
	logic [15:0] write_time;
	logic [15:0] write_date;
	logic [15:0] create_time;
	logic [15:0] create_date;
	logic [15:0] access_date;
	logic [7:0]  create_tenths;
	logic        last;

	fat_directory_entry_scanner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.dir_byte      (dir_byte),
		.start_of_scan (start_of_scan),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.name_char     (name_char),
		.attributes    (attributes),
		.first_cluster (first_cluster),
		.file_length   (file_length),
		.write_time    (write_time),
		.write_date    (write_date),
		.create_time   (create_time),
		.create_date   (create_date),
		.access_date   (access_date),
		.create_tenths (create_tenths),
		.last          (last)
	);

	// Mirror of the scanner state.
	logic [4:0]  scan_pos;
	logic [7:0]  name_bytes [NAME_LEN];
	logic [7:0]  attr_byte;
	logic [7:0]  tenths_byte;
	logic [15:0] entry_words [NUM_WORDS];
	logic [31:0] size_word;
	logic        skip_pending;
	logic        dir_ended;
	logic        skip_setting;

	dir_result_t awaited_results [$];

	int  mismatch_count = 0;
	int  results_checked = 0;
	int  results_predicted = 0;
	int  bytes_used = 0;
	int  bytes_ignored = 0;
	int  skip_writes = 0;
	int  holds_done = 0;
	int  cycle_count = 0;
	int  next_gap = 0;
	bit  valid_held = 1'b0;
	bit  no_idle = 1'b0;
	bit  hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LINES) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
				results_checked, fname, got, want));
		end
	endtask

	// Predicts the results that one accepted directory byte causes.
	task automatic scan_dir_byte(input logic [7:0] b, input logic sos);
		dir_result_t r;
		logic [7:0]  c;
		logic [7:0]  cleaned [12];
		int          n;
		int          w;
		if (sos) begin
			scan_pos = '0;
			dir_ended = 1'b0;
			skip_pending = skip_setting;
		end
		if (dir_ended) begin
			bytes_ignored++;
		end else begin
			bytes_used++;
			// Gather the byte at its little-endian entry offset.
			if (scan_pos < NAME_LEN) begin
				name_bytes[scan_pos] = b;
			end else if (scan_pos == ATTR_POS) begin
				attr_byte = b;
			end else if (scan_pos == TENTHS_POS) begin
				tenths_byte = b;
			end else if (scan_pos >= WORD_BASE_POS && scan_pos < WORD_BASE_POS + 2 * NUM_WORDS) begin
				w = (int'(scan_pos) - WORD_BASE_POS) / 2;
				if (scan_pos[0]) entry_words[w][15:8] = b;
				else entry_words[w][7:0] = b;
			end else if (scan_pos >= WORD_BASE_POS + 2 * NUM_WORDS) begin
				size_word[8 * scan_pos[1:0] +: 8] = b;
			end

			if (scan_pos != ENTRY_LAST_POS) begin
				scan_pos++;
			end else begin
				scan_pos = '0;
				r = '0;
				if (skip_pending) begin
					skip_pending = 1'b0;
				end else if (name_bytes[0] == NUL_CHAR) begin
					// A zero first name byte closes the directory.
					dir_ended = 1'b1;
					r.kind = KIND_END;
					r.last_flag = 1'b1;
					awaited_results.push_back(r);
					results_predicted++;
				end else if (name_bytes[0] != DELETED_MARK && name_bytes[2] != NUL_CHAR) begin
					// Clean the 8.3 name: lower-case letters, drop spaces, insert the dot.
					n = 0;
					for (int i = 0; i < NAME_LEN; i++) begin
						c = name_bytes[i];
						if (i == BASE_LEN) begin
							cleaned[n] = DOT_CHAR;
							n++;
						end
						if (c >= UPPER_A && c <= UPPER_Z) c = c + SPACE_CHAR;
						if (c != SPACE_CHAR) begin
							cleaned[n] = c;
							n++;
						end
					end
					r.kind = KIND_NAME;
					r.attr = attr_byte;
					r.cluster = {entry_words[WORD_CLUS_HI], entry_words[WORD_CLUS_LO]};
					r.length = size_word;
					r.wtime = entry_words[WORD_WTIME];
					r.wdate = entry_words[WORD_WDATE];
					r.ctime = entry_words[WORD_CTIME];
					r.cdate = entry_words[WORD_CDATE];
					r.adate = entry_words[WORD_ADATE];
					r.tenths = tenths_byte;
					for (int i = 0; i < n; i++) begin
						r.ch = cleaned[i];
						r.last_flag = (i == n - 1);
						awaited_results.push_back(r);
						results_predicted++;
					end
				end
			end
		end
	endtask

	// Offers one byte request and waits for it to be taken.
	task automatic send_byte(input logic [7:0] b, input logic sos);
		repeat (next_gap) @(negedge clk);
		in_valid <= 1'b1;
		dir_byte <= b;
		start_of_scan <= sos;
		valid_held = 1'b1;
		do @(posedge clk); while (!in_ready);
		scan_dir_byte(b, sos);
		@(negedge clk);
		next_gap = no_idle ? 0 : $urandom_range(0, 7);
		if (next_gap != 0) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
	endtask

	task automatic end_burst();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		@(negedge clk);
		next_gap = 0;
	endtask

	task automatic wait_drained();
		end_burst();
		while (awaited_results.size() != 0) @(negedge clk);
	endtask

	// Writes skip_first_entry while the scanner is idle.
	task automatic write_skip(input logic v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		skip_setting = v;
		skip_writes++;
	endtask

	task automatic send_entry(input logic [255:0] ent, input logic sos);
		for (int i = 0; i < 32; i++) begin
			send_byte(ent[8 * i +: 8], sos && (i == 0));
		end
	endtask

	function automatic logic [87:0] name_bits(input string s);
		logic [87:0] nm;
		for (int i = 0; i < NAME_LEN; i++) nm[8 * i +: 8] = s[i];
		return nm;
	endfunction

	function automatic logic [87:0] random_name(input entry_kind_t kind);
		logic [87:0] nm;
		int          sel;
		for (int i = 0; i < NAME_LEN; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 9) nm[8 * i +: 8] = UPPER_A + 8'($urandom_range(0, 25));
			else if (sel < 13) nm[8 * i +: 8] = SPACE_CHAR;
			else if (sel < 15) nm[8 * i +: 8] = DIGIT_0 + 8'($urandom_range(0, 9));
			else nm[8 * i +: 8] = 8'($urandom);
		end
		case (kind)
			ENT_NAMED: begin
				if (nm[7:0] == NUL_CHAR || nm[7:0] == DELETED_MARK) nm[7:0] = UPPER_A;
				if (nm[23:16] == NUL_CHAR) nm[23:16] = UPPER_Z;
			end
			ENT_DELETED: begin
				nm[7:0] = DELETED_MARK;
			end
			ENT_LONG_NAME: begin
				nm[23:16] = NUL_CHAR;
				if (nm[7:0] == NUL_CHAR) nm[7:0] = UPPER_A;
			end
			default: begin
				nm[7:0] = NUL_CHAR;
			end
		endcase
		return nm;
	endfunction

	// Random metadata around a name of the given kind.
	function automatic logic [255:0] random_entry(input entry_kind_t kind);
		logic [255:0] ent;
		for (int i = 0; i < 8; i++) ent[32 * i +: 32] = $urandom;
		ent[87:0] = random_name(kind);
		if (kind == ENT_LONG_NAME) ent[95:88] = LFN_ATTR;
		return ent;
	endfunction

	// After reset no scan has started, so the first entry is not skipped. Its name
	// covers the letter range edges, a zero byte, 0xFF and a space in the extension.
	task automatic test_no_scan_started();
		send_entry({{21{8'h00}}, 8'h7A, SPACE_CHAR, 8'h61, 8'h7B, 8'h60, 8'hFF,
			8'h5B, UPPER_A, UPPER_Z, NUL_CHAR, 8'h40}, 1'b0);
	endtask

	// Skipped first entry, then the end marker and ignored bytes.
	task automatic test_skip_and_end();
		logic [255:0] ent;
		ent = {{21{8'h5A}}, name_bits("XSKIPPEDBIN")};
		send_entry(ent, 1'b1);
		send_entry(random_entry(ENT_END), 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(NUL_CHAR, 1'b0);
	endtask

	// Skip turned off between scans: the next scan's first entry, a twelve-character
	// name, is given. The receiver starts a long hold once it has taken the first character.
	task automatic test_config_write();
		logic [255:0] ent;
		write_skip(1'b0);
		hold_request = 1'b1;
		no_idle = 1'b1;
		ent = random_entry(ENT_NAMED);
		ent[87:0] = name_bits("ABCDEFGHIJK");
		send_entry(ent, 1'b1);
	endtask

	// A deleted entry keeps being offered while the receiver holds off, then a drain.
	task automatic test_backpressure();
		send_entry(random_entry(ENT_DELETED), 1'b0);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// Receiver: random stall before each result, or a long hold when requested.
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
				holds_done++;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Compare each taken result with the oldest expectation.
	always @(posedge clk) begin : result_check
		dir_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: kind %0d name_char %02h",
					result_kind, name_char));
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", result_kind, want.kind);
				check_field("name_char", name_char, want.ch);
				check_field("attributes", attributes, want.attr);
				check_field("first_cluster", first_cluster, want.cluster);
				check_field("file_length", file_length, want.length);
				check_field("write_time", write_time, want.wtime);
				check_field("write_date", write_date, want.wdate);
				check_field("create_time", create_time, want.ctime);
				check_field("create_date", create_date, want.cdate);
				check_field("access_date", access_date, want.adate);
				check_field("create_tenths", create_tenths, want.tenths);
				check_field("last", last, want.last_flag);
			end
		end
	end

	// Run limit.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : main
		int drain_wait;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		dir_byte = '0;
		start_of_scan = 1'b0;
		scan_pos = '0;
		for (int i = 0; i < NAME_LEN; i++) name_bytes[i] = '0;
		for (int i = 0; i < NUM_WORDS; i++) entry_words[i] = '0;
		attr_byte = '0;
		tenths_byte = '0;
		size_word = '0;
		skip_pending = 1'b0;
		dir_ended = 1'b0;
		skip_setting = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_no_scan_started();
		test_skip_and_end();
		test_config_write();
		test_backpressure();

		// Let the last results come out, then allow for trailing activity.
		end_burst();
		drain_wait = 0;
		while (awaited_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				awaited_results.size()));
		end

		$display("Run covered %0d entry bytes (%0d ignored after an end marker) and %0d results.",
			bytes_used, bytes_ignored, results_checked);
		$display("Skip setting written %0d times, %0d long receiver holds with a stalled input.",
			skip_writes, holds_done);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
